// ----- hdl/bsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types, codes and sizes of the bitmap slot allocator store.
// ----------------------------------------------------------------------------
package bsa_pkg;

	// Store geometry
	localparam int SLOTS      = 64;
	localparam int MAX_LAYERS = 8;
	localparam int MAX_DIM    = 64;

	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int LAYER_W = $clog2(MAX_LAYERS);
	localparam int ELEM_W  = $clog2(MAX_DIM);
	localparam int ADDR_W  = LAYER_W + SLOT_W + ELEM_W;
	localparam int DEPTH   = SLOTS * MAX_LAYERS * MAX_DIM;

	// Config register widths
	localparam int CFG_SLOTS_W  = 7;
	localparam int CFG_LAYERS_W = 4;
	localparam int CFG_DIM_W    = 7;

	localparam int DATA_W   = 64;
	localparam int STATUS_W = 2;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	// Request codes
	typedef enum logic [1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_WRITE   = 2'd1,
		REQ_READ    = 2'd2,
		REQ_RELEASE = 2'd3
	} req_t;

	// Status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

	// Register indexes (word address)
	typedef enum logic [1:0] {
		REG_SLOTS  = 2'd0,
		REG_LAYERS = 2'd1,
		REG_DIM    = 2'd2
	} reg_idx_t;

	// Free map request from the front end
	typedef struct packed {
		logic                   alloc;
		logic                   release_en;
		logic [SLOT_W-1:0]      rel_slot;
		logic [CFG_SLOTS_W-1:0] slots_cfg;
	} fm_req_t;

	// Free map answer
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] idx;
		logic              full_next;
	} fm_rsp_t;

endpackage

// ----- hdl/bsa_free_map.sv -----
// ----------------------------------------------------------------------------
// bsa_free_map
// One free bit per slot, lowest-free search, allocate/release update and
// full flag for the map as it stands after the current request.
// ----------------------------------------------------------------------------
module bsa_free_map (
	input  logic             clk,
	input  logic             arst_n,
	input  bsa_pkg::fm_req_t req,
	output bsa_pkg::fm_rsp_t rsp
);

	logic [bsa_pkg::SLOTS-1:0]  free_q;
	logic [bsa_pkg::SLOTS-1:0]  free_nxt;
	logic [bsa_pkg::SLOTS-1:0]  offer_mask;
	logic [bsa_pkg::SLOTS-1:0]  cand;
	logic [bsa_pkg::SLOT_W-1:0] low_idx;

	// Slots currently offered
	always_comb begin
		for (int i = 0; i < bsa_pkg::SLOTS; i++) begin
			offer_mask[i] = (bsa_pkg::CFG_SLOTS_W'(i) < req.slots_cfg);
		end
	end

	assign cand = free_q & offer_mask;

	// Priority encoder: lowest free offered slot
	always_comb begin
		low_idx = '0;
		for (int i = bsa_pkg::SLOTS - 1; i >= 0; i--) begin
			if (cand[i]) begin
				low_idx = bsa_pkg::SLOT_W'(i);
			end
		end
	end

	// Next map
	always_comb begin
		free_nxt = free_q;
		if (req.alloc && (|cand)) begin
			free_nxt[low_idx] = 1'b0;
		end
		if (req.release_en) begin
			free_nxt[req.rel_slot] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
		end else begin
			free_q <= free_nxt;
		end
	end

	assign rsp.found     = |cand;
	assign rsp.idx       = low_idx;
	assign rsp.full_next = ~|(free_nxt & offer_mask);

endmodule

// ----- hdl/bitmap_slot_allocator_store_core.sv -----
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_store_core
// Slot allocator with a per-slot key/value element store.
//
//   channel   signals                                    direction
//   req       req_valid/req_stall + request fields       in
//   rsp       rsp_valid/rsp_stall + status, slot_index,  out
//             read_data, block_full
//   apb       psel/penable/pwrite/paddr/pwdata/prdata    config
//
// One request per cycle unless a stalled response blocks it; its response
// appears the cycle after acceptance, registered with the element memory reads.
// The free map search and update finish in the accept cycle.
// A stalled response holds and blocks new requests (req_stall).
// Reset frees every slot and restores the config registers; the element
// memories are not cleared.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_store_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// request
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [1:0]                     req_type,
	input  logic [bsa_pkg::SLOT_W-1:0]     slot,
	input  logic [bsa_pkg::LAYER_W-1:0]    layer_sel,
	input  logic [bsa_pkg::ELEM_W-1:0]     element,
	input  logic                           is_value,
	input  logic [bsa_pkg::DATA_W-1:0]     data_word,
	// response
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [bsa_pkg::STATUS_W-1:0]   status,
	output logic [bsa_pkg::SLOT_W-1:0]     slot_index,
	output logic [bsa_pkg::DATA_W-1:0]     read_data,
	output logic                           block_full,
	// config
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bsa_pkg::PADDR_W-1:0]    paddr,
	input  logic [bsa_pkg::PDATA_W-1:0]    pwdata,
	output logic [bsa_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready
);

	// Config registers
	logic [bsa_pkg::CFG_SLOTS_W-1:0]  slots_cfg_q;
	logic [bsa_pkg::CFG_LAYERS_W-1:0] layers_cfg_q;
	logic [bsa_pkg::CFG_DIM_W-1:0]    dim_cfg_q;
	logic                             cfg_wr;
	bsa_pkg::reg_idx_t                reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign reg_idx = bsa_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_cfg_q  <= bsa_pkg::CFG_SLOTS_W'(bsa_pkg::SLOTS);
			layers_cfg_q <= bsa_pkg::CFG_LAYERS_W'(bsa_pkg::MAX_LAYERS);
			dim_cfg_q    <= bsa_pkg::CFG_DIM_W'(bsa_pkg::MAX_DIM);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				bsa_pkg::REG_SLOTS:  slots_cfg_q  <= pwdata[bsa_pkg::CFG_SLOTS_W-1:0];
				bsa_pkg::REG_LAYERS: layers_cfg_q <= pwdata[bsa_pkg::CFG_LAYERS_W-1:0];
				bsa_pkg::REG_DIM:    dim_cfg_q    <= pwdata[bsa_pkg::CFG_DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (reg_idx)
			bsa_pkg::REG_SLOTS:  prdata = bsa_pkg::PDATA_W'(slots_cfg_q);
			bsa_pkg::REG_LAYERS: prdata = bsa_pkg::PDATA_W'(layers_cfg_q);
			bsa_pkg::REG_DIM:    prdata = bsa_pkg::PDATA_W'(dim_cfg_q);
			default:             prdata = '0;
		endcase
	end

	// Request decode and range checks
	logic acc;
	logic is_alloc, is_write, is_read, is_rel;
	logic slot_ok, elem_ok, req_ok;

	assign req_stall = rsp_valid & rsp_stall;
	assign acc       = req_valid & ~req_stall;

	assign is_alloc = (req_type == bsa_pkg::REQ_ALLOC);
	assign is_write = (req_type == bsa_pkg::REQ_WRITE);
	assign is_read  = (req_type == bsa_pkg::REQ_READ);
	assign is_rel   = (req_type == bsa_pkg::REQ_RELEASE);

	assign slot_ok = ({1'b0, slot} < slots_cfg_q);
	assign elem_ok = ({1'b0, layer_sel} < layers_cfg_q) && ({1'b0, element} < dim_cfg_q);
	assign req_ok  = is_rel ? slot_ok : (slot_ok & elem_ok);

	// Free map
	bsa_pkg::fm_req_t fm_req;
	bsa_pkg::fm_rsp_t fm_rsp;

	assign fm_req.alloc      = acc & is_alloc;
	assign fm_req.release_en = acc & is_rel & slot_ok;
	assign fm_req.rel_slot   = slot;
	assign fm_req.slots_cfg  = slots_cfg_q;

	bsa_free_map u_free_map (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fm_req),
		.rsp    (fm_rsp)
	);

	// Element memories, address {layer, slot, element}
	logic [bsa_pkg::DATA_W-1:0] key_mem [bsa_pkg::DEPTH];
	logic [bsa_pkg::DATA_W-1:0] val_mem [bsa_pkg::DEPTH];
	logic [bsa_pkg::DATA_W-1:0] key_rd_q, val_rd_q;
	logic [bsa_pkg::ADDR_W-1:0] mem_addr;
	logic                       wr_en, rd_en;

	assign mem_addr = {layer_sel, slot, element};
	assign wr_en    = acc & is_write & req_ok;
	assign rd_en    = acc & is_read & req_ok;

	always_ff @(posedge clk) begin
		if (wr_en && !is_value) begin
			key_mem[mem_addr] <= data_word;
		end
		if (rd_en) begin
			key_rd_q <= key_mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && is_value) begin
			val_mem[mem_addr] <= data_word;
		end
		if (rd_en) begin
			val_rd_q <= val_mem[mem_addr];
		end
	end

	// Response fields for this beat
	bsa_pkg::status_t           status_d;
	logic [bsa_pkg::SLOT_W-1:0] slot_d;

	always_comb begin
		if (is_alloc) begin
			status_d = fm_rsp.found ? bsa_pkg::ST_OK : bsa_pkg::ST_NO_FREE;
			slot_d   = fm_rsp.found ? fm_rsp.idx : '0;
		end else begin
			status_d = req_ok ? bsa_pkg::ST_OK : bsa_pkg::ST_RANGE;
			slot_d   = slot;
		end
	end

	// Response stage
	bsa_pkg::status_t           status_s1;
	logic [bsa_pkg::SLOT_W-1:0] slot_s1;
	logic                       full_s1;
	logic                       isv_s1;
	logic                       rd_s1;
	logic                       rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rd_s1       <= 1'b0;
		end else if (acc) begin
			rsp_valid_q <= 1'b1;
			rd_s1       <= rd_en;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= status_d;
			slot_s1   <= slot_d;
			full_s1   <= fm_rsp.full_next;
			isv_s1    <= is_value;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_s1;
	assign slot_index = slot_s1;
	assign block_full = full_s1;
	assign read_data  = rd_s1 ? (isv_s1 ? val_rd_q : key_rd_q) : '0;

endmodule

// ----- hdl/bsa_checker.sv -----
// ----------------------------------------------------------------------------
// bsa_checker
// Port-level checks of the slot allocator store, bound to the top level.
// ----------------------------------------------------------------------------
module bsa_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_stall,
	input logic                         rsp_valid,
	input logic                         rsp_stall,
	input logic [bsa_pkg::STATUS_W-1:0] status,
	input logic [bsa_pkg::SLOT_W-1:0]   slot_index,
	input logic [bsa_pkg::DATA_W-1:0]   read_data,
	input logic                         block_full
);

	// Stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(slot_index)
			&& $stable(read_data) && $stable(block_full))
		else $error("stalled response changed");

	// Every accepted request yields a response in the next cycle
	a_req_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("accepted request gave no response");

	// Failed allocate means the block is full and reports slot zero
	a_no_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == bsa_pkg::ST_NO_FREE |-> block_full && slot_index == '0)
		else $error("no-free response inconsistent");

	// Read data only on successful beats
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != bsa_pkg::ST_OK |-> read_data == '0)
		else $error("read data on failed request");

endmodule

bind bitmap_slot_allocator_store_core bsa_checker u_bsa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_valid),
	.req_stall  (req_stall),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.status     (status),
	.slot_index (slot_index),
	.read_data  (read_data),
	.block_full (block_full)
);
